// File: rtl/drse_pkg.sv
`default_nettype none
package drse_pkg;

  localparam int OPC_W = 2;
  localparam int VAL_W = 32;
  localparam int RNG_W = 13;
  localparam int SUM_W = 48;
  localparam int ERR_W = 2;

  localparam logic [OPC_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OPC_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  typedef logic signed [SUM_W-1:0] sum_t;

endpackage
`default_nettype wire

// File: rtl/drse_stream_if.sv
`default_nettype none
interface drse_in_if import drse_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OPC_W-1:0]        opcode;
  logic signed [VAL_W-1:0] value;
  logic [RNG_W-1:0]        range_left;
  logic [RNG_W-1:0]        range_right;

  modport source (output valid, opcode, value, range_left, range_right, input ready);
  modport sink   (input valid, opcode, value, range_left, range_right, output ready);
endinterface

interface drse_out_if import drse_pkg::*; ();
  logic             valid;
  logic             ready;
  sum_t             distinct_sum;
  logic [ERR_W-1:0] error_code;

  modport source (output valid, distinct_sum, error_code, input ready);
  modport sink   (input valid, distinct_sum, error_code, output ready);
endinterface
`default_nettype wire

// File: rtl/distinct_range_sum_engine_top.sv
// distinct value range sum engine over a persistent segment tree
// in_ch carries one word per operation: append a value at the next position,
// query the sum of distinct values in range_left..range_right, or clear.
// out_ch carries one word per query, and one per failed append (pool or
// length full, error_code 2); successful appends, clears and opcode 3 give none.
// an append scans the distinct-value slots one per cycle, sizes each tree
// path level by level, then walks each path through the node memory, which
// has one read and one write port: a read per level going down, then a write
// per level for the write-back. a new value takes one path; a repeated one
// takes two, first clearing its old position. the path depth is 13 levels at
// the default length. a query walks one path of the node memory.
// all stores are tracked by fill counts, so reset and clear take effect at
// once with no sweep of the memories.
// in_ch.ready is high only while no operation is in progress. a finished
// result sits in the output register until taken; appends keep going behind
// it, and the next result waits until the register is free.
`default_nettype none
module distinct_range_sum_engine_top
  import drse_pkg::*;
#(
  parameter int MAX_LEN   = 4096,
  parameter int NODE_POOL = 163840
) (
  input  wire        clk,
  input  wire        rst_n,
  drse_in_if.sink    in_ch,
  drse_out_if.source out_ch
);

  localparam int POS_W  = $clog2(MAX_LEN + 1);
  localparam int SLOT_W = $clog2(MAX_LEN);
  localparam int AAW    = $clog2(MAX_LEN + 1);
  localparam int NAW    = $clog2(NODE_POOL);
  localparam int NODE_W = $clog2(NODE_POOL + 1);
  localparam int LVL    = $clog2(MAX_LEN) + 1;
  localparam int LVL_W  = $clog2(LVL);
  localparam int NEED_W = $clog2(2 * LVL + 1);
  localparam int QW     = (POS_W > RNG_W) ? POS_W : RNG_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_LEN   = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_ROOT  = 4'd4;
  localparam logic [3:0] S_DESC  = 4'd5;
  localparam logic [3:0] S_DATA  = 4'd6;
  localparam logic [3:0] S_WRT   = 4'd7;
  localparam logic [3:0] S_FIN1  = 4'd8;
  localparam logic [3:0] S_FIN2  = 4'd9;
  localparam logic [3:0] S_QROOT = 4'd10;
  localparam logic [3:0] S_QDESC = 4'd11;
  localparam logic [3:0] S_QDATA = 4'd12;
  localparam logic [3:0] S_RES   = 4'd13;

  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

  typedef struct packed {
    logic [NAW-1:0] left;
    logic [NAW-1:0] right;
    sum_t           sum;
  } node_t;

  typedef struct packed {
    logic [NAW-1:0]   root;
    logic [VAL_W-1:0] key;
    logic [POS_W-1:0] pos;
  } aux_t;

  // memories
  node_t node_mem [NODE_POOL];
  aux_t  aux_mem  [MAX_LEN + 1];

  node_t          node_rd_r;
  logic           node_zero_r;
  aux_t           aux_rd_r;

  logic           node_re, node_we;
  logic [NAW-1:0] node_ra, node_wa;
  node_t          node_wd;
  logic           aux_re, aux_we_slot, aux_we_root;
  logic [AAW-1:0] aux_ra, aux_wa;
  logic [VAL_W-1:0] aux_wkey;
  logic [POS_W-1:0] aux_wpos;
  logic [NAW-1:0]   aux_wroot;

  always_ff @(posedge clk) begin
    if (node_re) begin
      node_rd_r   <= node_mem[node_ra];
      node_zero_r <= (node_ra == '0);
    end
    if (node_we) node_mem[node_wa] <= node_wd;
  end

  always_ff @(posedge clk) begin
    if (aux_re) aux_rd_r <= aux_mem[aux_ra];
    if (aux_we_slot) begin
      aux_mem[aux_wa].key <= aux_wkey;
      aux_mem[aux_wa].pos <= aux_wpos;
    end
    if (aux_we_root) aux_mem[aux_wa].root <= aux_wroot;
  end

  // control state
  logic [3:0]        state_r, state_nxt;
  logic [POS_W-1:0]  loaded_r, loaded_nxt;
  logic [NODE_W-1:0] nfree_r, nfree_nxt;
  logic [POS_W-1:0]  dcount_r, dcount_nxt;
  logic [POS_W-1:0]  issue_r, issue_nxt;
  logic              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic [VAL_W-1:0]  key_r, key_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              found_r, found_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] pidx_r, pidx_nxt;
  logic [POS_W-1:0]  oldpos_r, oldpos_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic              pass_r, pass_nxt;
  logic [POS_W-1:0]  tgt_r, tgt_nxt;
  logic [POS_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [NAW-1:0]    cur_r, cur_nxt;
  logic [NAW-1:0]    base_r, base_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [LVL_W-1:0]  wk_r, wk_nxt;
  sum_t              vnew_r, vnew_nxt;
  sum_t              delta_r, delta_nxt;
  sum_t              stk_sum_r [LVL];
  sum_t              stk_sum_nxt [LVL];
  logic              stk_side_r [LVL];
  logic              stk_side_nxt [LVL];
  logic [NAW-1:0]    stk_sib_r [LVL];
  logic [NAW-1:0]    stk_sib_nxt [LVL];
  logic [POS_W-1:0]  ql_r, ql_nxt;
  logic              arr_r, arr_nxt;
  sum_t              acc_r, acc_nxt;
  sum_t              res_sum_r, res_sum_nxt;
  logic [ERR_W-1:0]  res_err_r, res_err_nxt;
  sum_t              out_sum_r, out_sum_nxt;
  logic [ERR_W-1:0]  out_err_r, out_err_nxt;

  logic [POS_W:0]     mid_sum;
  logic [POS_W-1:0]   mid;
  node_t              nd;
  logic [QW-1:0]      ql_ext, qr_ext, ld_ext;
  logic               go_right;
  sum_t               term;
  logic [NODE_W:0]    pool_need;
  logic [NODE_W-1:0]  nfree_add;
  logic               hit;
  logic [NAW-1:0]     wnext;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[POS_W:1];
  assign nd      = node_zero_r ? '0 : node_rd_r;
  assign ql_ext  = QW'(in_ch.range_left);
  assign qr_ext  = QW'(in_ch.range_right);
  assign ld_ext  = QW'(loaded_r);
  assign pool_need = {1'b0, nfree_r} + (NODE_W + 1)'(need_r);
  assign nfree_add = nfree_r + NODE_W'(lvl_r) + NODE_W'(1);
  assign hit     = pend_r && (aux_rd_r.key == key_r);
  assign wnext   = base_r + NAW'(wk_r) + NAW'(1);

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.distinct_sum = out_sum_r;
  assign out_ch.error_code   = out_err_r;

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    nfree_nxt     = nfree_r;
    dcount_nxt    = dcount_r;
    issue_nxt     = issue_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    pidx_nxt      = pidx_r;
    oldpos_nxt    = oldpos_r;
    need_nxt      = need_r;
    pass_nxt      = pass_r;
    tgt_nxt       = tgt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cur_nxt       = cur_r;
    base_nxt      = base_r;
    lvl_nxt       = lvl_r;
    wk_nxt        = wk_r;
    vnew_nxt      = vnew_r;
    delta_nxt     = delta_r;
    stk_sum_nxt   = stk_sum_r;
    stk_side_nxt  = stk_side_r;
    stk_sib_nxt   = stk_sib_r;
    ql_nxt        = ql_r;
    arr_nxt       = arr_r;
    acc_nxt       = acc_r;
    res_sum_nxt   = res_sum_r;
    res_err_nxt   = res_err_r;
    out_sum_nxt   = out_sum_r;
    out_err_nxt   = out_err_r;

    node_re     = 1'b0;
    node_ra     = cur_r;
    node_we     = 1'b0;
    node_wa     = base_r + NAW'(wk_r);
    node_wd     = '0;
    aux_re      = 1'b0;
    aux_ra      = AAW'(issue_r);
    aux_we_slot = 1'b0;
    aux_we_root = 1'b0;
    aux_wa      = AAW'(pos_r);
    aux_wkey    = key_r;
    aux_wpos    = pos_r;
    aux_wroot   = base_r;
    go_right    = 1'b0;
    term        = '0;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.opcode)
            OP_APPEND: begin
              if (loaded_r == POS_MAX) begin
                res_sum_nxt = '0;
                res_err_nxt = ERR_FULL;
                state_nxt   = S_RES;
              end else begin
                key_nxt   = in_ch.value;
                pos_nxt   = loaded_r + POS_ONE;
                issue_nxt = '0;
                pend_nxt  = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            OP_QUERY: begin
              if (ql_ext == '0 || qr_ext < ql_ext || qr_ext > ld_ext) begin
                res_sum_nxt = '0;
                res_err_nxt = ERR_RANGE;
                state_nxt   = S_RES;
              end else begin
                ql_nxt    = ql_ext[POS_W-1:0];
                aux_re    = 1'b1;
                aux_ra    = qr_ext[AAW-1:0];
                state_nxt = S_QROOT;
              end
            end
            OP_CLEAR: begin
              loaded_nxt = '0;
              nfree_nxt  = NODE_W'(1);
              dcount_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      // one slot read per cycle, compared the cycle after
      S_SCAN: begin
        if (hit || issue_r >= dcount_r) begin
          found_nxt  = hit;
          slot_nxt   = hit ? pidx_r : dcount_r[SLOT_W-1:0];
          oldpos_nxt = aux_rd_r.pos;
          tgt_nxt    = hit ? aux_rd_r.pos : pos_r;
          pass_nxt   = !hit;
          lo_nxt     = POS_ONE;
          hi_nxt     = POS_MAX;
          need_nxt   = '0;
          pend_nxt   = 1'b0;
          state_nxt  = S_LEN;
        end else begin
          aux_re    = 1'b1;
          aux_ra    = AAW'(issue_r);
          pend_nxt  = 1'b1;
          pidx_nxt  = issue_r[SLOT_W-1:0];
          issue_nxt = issue_r + POS_ONE;
        end
      end

      // count the nodes each path will take
      S_LEN: begin
        need_nxt = need_r + NEED_W'(1);
        if (lo_r >= hi_r) begin
          lo_nxt = POS_ONE;
          hi_nxt = POS_MAX;
          if (!pass_r) begin
            pass_nxt = 1'b1;
            tgt_nxt  = pos_r;
          end else begin
            state_nxt = S_CHK;
          end
        end else if (tgt_r <= mid) begin
          hi_nxt = mid;
        end else begin
          lo_nxt = mid + POS_ONE;
        end
      end

      S_CHK: begin
        if (pool_need > (NODE_W + 1)'(NODE_POOL)) begin
          res_sum_nxt = '0;
          res_err_nxt = ERR_FULL;
          state_nxt   = S_RES;
        end else begin
          aux_re    = 1'b1;
          aux_ra    = AAW'(loaded_r);
          pass_nxt  = !found_r;
          tgt_nxt   = found_r ? oldpos_r : pos_r;
          vnew_nxt  = found_r ? '0 : {{(SUM_W - VAL_W){key_r[VAL_W-1]}}, key_r};
          state_nxt = S_ROOT;
        end
      end

      S_ROOT: begin
        cur_nxt   = (loaded_r == '0) ? '0 : aux_rd_r.root;
        lo_nxt    = POS_ONE;
        hi_nxt    = POS_MAX;
        lvl_nxt   = '0;
        base_nxt  = nfree_r[NAW-1:0];
        state_nxt = S_DESC;
      end

      S_DESC: begin
        node_re   = 1'b1;
        node_ra   = cur_r;
        state_nxt = S_DATA;
      end

      S_DATA: begin
        stk_sum_nxt[lvl_r] = nd.sum;
        if (lo_r >= hi_r) begin
          delta_nxt = vnew_r - nd.sum;
          wk_nxt    = '0;
          state_nxt = S_WRT;
        end else begin
          go_right            = (tgt_r > mid);
          stk_side_nxt[lvl_r] = go_right;
          stk_sib_nxt[lvl_r]  = go_right ? nd.left : nd.right;
          cur_nxt             = go_right ? nd.right : nd.left;
          if (go_right) lo_nxt = mid + POS_ONE;
          else          hi_nxt = mid;
          lvl_nxt   = lvl_r + LVL_W'(1);
          state_nxt = S_DESC;
        end
      end

      // every node on the path shifts by the change at the leaf
      S_WRT: begin
        node_we     = 1'b1;
        node_wa     = base_r + NAW'(wk_r);
        node_wd.sum = stk_sum_r[wk_r] + delta_r;
        if (wk_r == lvl_r) begin
          node_wd.left  = '0;
          node_wd.right = '0;
          nfree_nxt     = nfree_add;
          if (!pass_r) begin
            pass_nxt  = 1'b1;
            cur_nxt   = base_r;
            tgt_nxt   = pos_r;
            vnew_nxt  = {{(SUM_W - VAL_W){key_r[VAL_W-1]}}, key_r};
            lo_nxt    = POS_ONE;
            hi_nxt    = POS_MAX;
            lvl_nxt   = '0;
            base_nxt  = nfree_add[NAW-1:0];
            state_nxt = S_DESC;
          end else begin
            state_nxt = S_FIN1;
          end
        end else begin
          node_wd.left  = stk_side_r[wk_r] ? stk_sib_r[wk_r] : wnext;
          node_wd.right = stk_side_r[wk_r] ? wnext : stk_sib_r[wk_r];
          wk_nxt        = wk_r + LVL_W'(1);
        end
      end

      S_FIN1: begin
        aux_we_slot = 1'b1;
        aux_wa      = AAW'(slot_r);
        state_nxt   = S_FIN2;
      end

      // slot count and length move together
      S_FIN2: begin
        aux_we_root = 1'b1;
        aux_wa      = AAW'(pos_r);
        aux_wroot   = base_r;
        loaded_nxt  = pos_r;
        if (!found_r) dcount_nxt = dcount_r + POS_ONE;
        state_nxt   = S_IDLE;
      end

      S_QROOT: begin
        cur_nxt   = aux_rd_r.root;
        lo_nxt    = POS_ONE;
        hi_nxt    = POS_MAX;
        arr_nxt   = 1'b1;
        acc_nxt   = '0;
        state_nxt = S_QDESC;
      end

      S_QDESC: begin
        node_re   = 1'b1;
        node_ra   = cur_r;
        state_nxt = S_QDATA;
      end

      // a node entered to the right adds its sum, one left to the right takes it off
      S_QDATA: begin
        go_right = (ql_r > lo_r) && (ql_r > mid);
        if (arr_r && !go_right)      term = nd.sum;
        else if (!arr_r && go_right) term = -nd.sum;
        else                         term = '0;
        acc_nxt = acc_r + term;
        if (ql_r <= lo_r) begin
          res_sum_nxt = acc_r + term;
          res_err_nxt = ERR_OK;
          state_nxt   = S_RES;
        end else begin
          arr_nxt = go_right;
          cur_nxt = go_right ? nd.right : nd.left;
          if (go_right) lo_nxt = mid + POS_ONE;
          else          hi_nxt = mid;
          state_nxt = S_QDESC;
        end
      end

      S_RES: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = res_sum_r;
          out_err_nxt   = res_err_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= '0;
      nfree_r     <= NODE_W'(1);
      dcount_r    <= '0;
      issue_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      nfree_r     <= nfree_nxt;
      dcount_r    <= dcount_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    pos_r      <= pos_nxt;
    found_r    <= found_nxt;
    slot_r     <= slot_nxt;
    pidx_r     <= pidx_nxt;
    oldpos_r   <= oldpos_nxt;
    need_r     <= need_nxt;
    pass_r     <= pass_nxt;
    tgt_r      <= tgt_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    cur_r      <= cur_nxt;
    base_r     <= base_nxt;
    lvl_r      <= lvl_nxt;
    wk_r       <= wk_nxt;
    vnew_r     <= vnew_nxt;
    delta_r    <= delta_nxt;
    stk_sum_r  <= stk_sum_nxt;
    stk_side_r <= stk_side_nxt;
    stk_sib_r  <= stk_sib_nxt;
    ql_r       <= ql_nxt;
    arr_r      <= arr_nxt;
    acc_r      <= acc_nxt;
    res_sum_r  <= res_sum_nxt;
    res_err_r  <= res_err_nxt;
    out_sum_r  <= out_sum_nxt;
    out_err_r  <= out_err_nxt;
  end

`ifndef SYNTHESIS
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nfree_r <= NODE_W'(NODE_POOL))
    else $error("node pool pointer beyond pool");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= POS_MAX)
    else $error("sequence length beyond capacity");

  a_slots_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dcount_r <= loaded_r)
    else $error("more distinct slots than positions");

  a_no_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
    node_we |-> (node_wa != '0))
    else $error("write to the empty node");

  a_res_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES && (!out_valid_r || out_ch.ready)) |=> out_valid_r)
    else $error("result not loaded into output register");
`endif

endmodule
`default_nettype wire
